// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the wheel speed controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/fwspd_pkg.sv -----
// Types and constants of the four-wheel PI speed controller.
`default_nettype none
package fwspd_pkg;

	localparam int WHEELS         = 4;
	localparam int WHEEL_W        = 2;
	localparam int SPEED_W        = 16;
	localparam int ERR_W          = SPEED_W + 1;
	localparam int INTEG_W        = 15;
	localparam int INTEG_SUM_W    = 18;
	localparam int INTEGRAL_LIMIT = 10000;
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int PROD_P_W       = 2 * ERR_W;
	localparam int PROD_I_W       = GAIN_W + 1 + INTEG_W;
	localparam int SUM_W          = 35;
	localparam int QUOT_W         = SUM_W - GAIN_FRAC_BITS;
	localparam int DRIVE_LIMIT    = 1000;
	localparam int DRIVE_W        = 11;
	localparam int LEG_W          = 10;
	localparam int CFG_IDX_W      = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI0 = 3'd4;

	localparam logic [GAIN_W-1:0] KP_RESET = 16'd1024;
	localparam logic [GAIN_W-1:0] KI_RESET = 16'd384;

	// Wheels whose forward drive goes to leg B
	localparam logic [WHEEL_W-1:0] WHEEL_FRONT_LEFT = 2'd0;
	localparam logic [WHEEL_W-1:0] WHEEL_REAR_RIGHT = 2'd3;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
	} gain_t;

endpackage
`default_nettype wire

// ----- src/fwspd_gain_regs.sv -----
// Per-wheel gain register file with write decode and wheel lookup.
`default_nettype none
module fwspd_gain_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fwspd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fwspd_pkg::GAIN_W-1:0]       cfg_data,
	input  wire logic [fwspd_pkg::WHEEL_W-1:0]      sel_wheel,
	output fwspd_pkg::gain_t                        gains
);

	logic [fwspd_pkg::GAIN_W-1:0] kp_q [fwspd_pkg::WHEELS];
	logic [fwspd_pkg::GAIN_W-1:0] ki_q [fwspd_pkg::WHEELS];

	// Register writes: low half of the index space is kp, upper half ki
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < fwspd_pkg::WHEELS; w++) begin
				kp_q[w] <= fwspd_pkg::KP_RESET;
				ki_q[w] <= fwspd_pkg::KI_RESET;
			end
		end else if (cfg_we) begin
			if (cfg_index < fwspd_pkg::REG_KI0) begin
				kp_q[cfg_index[fwspd_pkg::WHEEL_W-1:0]] <= cfg_data;
			end else begin
				ki_q[cfg_index[fwspd_pkg::WHEEL_W-1:0]] <= cfg_data;
			end
		end
	end

	// Gain lookup for the wheel in flight
	assign gains.kp = kp_q[sel_wheel];
	assign gains.ki = ki_q[sel_wheel];

endmodule
`default_nettype wire

// ----- src/four_wheel_pi_speed_controller_unit.sv -----
// A result is presented on m_tvalid after its input transaction passes the stage 1, 2, 3 and output registers.
// Throughput: one transaction per cycle while m_tready does not stall the output; the integral
// read-modify-write completes within stage 1, so back-to-back items on the same wheel need no stall.
// Stages: input/integral update, two gain multipliers, sum/truncate/clamp/legs.
// Reset: clears all valid flags and integrals, gains return to kp 4.0 and ki 1.5.
`default_nettype none
`include "assert_macros.svh"
module four_wheel_pi_speed_controller_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [31:0]                         s_tdata,  // target_speed, measured_speed
	input  wire logic [fwspd_pkg::WHEEL_W-1:0]       s_tuser,  // wheel
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [31:0]                              m_tdata,  // drive, reverse, leg_a, leg_b
	output logic [fwspd_pkg::WHEEL_W-1:0]            m_tuser,  // wheel_out
	input  wire logic                                cfg_we,
	input  wire logic [fwspd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fwspd_pkg::GAIN_W-1:0]        cfg_data
);

	localparam int ISW = fwspd_pkg::INTEG_SUM_W;
	localparam logic signed [ISW-1:0] INTEG_HI = ISW'(fwspd_pkg::INTEGRAL_LIMIT);
	localparam logic signed [ISW-1:0] INTEG_LO = -ISW'(fwspd_pkg::INTEGRAL_LIMIT);
	localparam int QW = fwspd_pkg::QUOT_W;
	localparam logic signed [QW-1:0] DRIVE_HI = QW'(fwspd_pkg::DRIVE_LIMIT);
	localparam logic signed [QW-1:0] DRIVE_LO = -QW'(fwspd_pkg::DRIVE_LIMIT);

	// Pipeline flow control: a stage loads when empty or when it drains
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_out;

	assign en_out   = !out_valid_q || m_tready;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v_s1        <= s_tvalid;
			if (en2)    v_s2        <= v_s1;
			if (en3)    v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	// Stage 1: input register
	logic [fwspd_pkg::WHEEL_W-1:0]        wheel_s1;
	logic signed [fwspd_pkg::SPEED_W-1:0] target_s1, measured_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			wheel_s1    <= s_tuser;
			target_s1   <= $signed(s_tdata[15:0]);
			measured_s1 <= $signed(s_tdata[31:16]);
		end
	end

	// Integral state, one entry per wheel
	logic [fwspd_pkg::WHEELS-1:0][fwspd_pkg::INTEG_W-1:0] integ_q;
	logic signed [fwspd_pkg::ERR_W-1:0]   err_s1;
	logic signed [ISW-1:0]                integ_sum;
	logic signed [fwspd_pkg::INTEG_W-1:0] acc_s1;
	logic                                 integ_upd;

	assign err_s1    = fwspd_pkg::ERR_W'(target_s1) - fwspd_pkg::ERR_W'(measured_s1);
	assign integ_sum = ISW'($signed(integ_q[wheel_s1])) + ISW'(err_s1);

	// Clamp the accumulated integral
	always_comb begin
		if (integ_sum > INTEG_HI) begin
			acc_s1 = fwspd_pkg::INTEG_W'(INTEG_HI);
		end else if (integ_sum < INTEG_LO) begin
			acc_s1 = fwspd_pkg::INTEG_W'(INTEG_LO);
		end else begin
			acc_s1 = integ_sum[fwspd_pkg::INTEG_W-1:0];
		end
	end

	assign integ_upd = v_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (integ_upd) begin
			integ_q[wheel_s1] <= acc_s1;
		end
	end

	// Gain lookup for the stage-1 wheel
	fwspd_pkg::gain_t gains_s1;

	fwspd_gain_regs u_gain_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel_wheel (wheel_s1),
		.gains     (gains_s1)
	);

	// Stage 2: operands for the two multipliers
	logic [fwspd_pkg::WHEEL_W-1:0]        wheel_s2;
	logic signed [fwspd_pkg::ERR_W-1:0]   err_s2;
	logic signed [fwspd_pkg::INTEG_W-1:0] acc_s2;
	fwspd_pkg::gain_t                     gains_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			wheel_s2 <= wheel_s1;
			err_s2   <= err_s1;
			acc_s2   <= acc_s1;
			gains_s2 <= gains_s1;
		end
	end

	logic signed [fwspd_pkg::PROD_P_W-1:0] prop_prod;
	logic signed [fwspd_pkg::PROD_I_W-1:0] integ_prod;

	assign prop_prod  = $signed({1'b0, gains_s2.kp}) * err_s2;
	assign integ_prod = $signed({1'b0, gains_s2.ki}) * acc_s2;

	// Stage 3: products
	logic [fwspd_pkg::WHEEL_W-1:0]         wheel_s3;
	logic signed [fwspd_pkg::PROD_P_W-1:0] prop_s3;
	logic signed [fwspd_pkg::PROD_I_W-1:0] integ_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			wheel_s3 <= wheel_s2;
			prop_s3  <= prop_prod;
			integ_s3 <= integ_prod;
		end
	end

	// Sum, divide by 2^frac truncating toward zero, clamp
	logic signed [fwspd_pkg::SUM_W-1:0]   sum_s3;
	logic signed [QW-1:0]                 quot_floor, quot;
	logic                                 round_up;
	logic signed [fwspd_pkg::DRIVE_W-1:0] drive_s3;
	logic                                 rev_s3, fwd_b;
	logic [fwspd_pkg::LEG_W-1:0]          mag_s3, leg_a_s3, leg_b_s3;
	logic signed [fwspd_pkg::DRIVE_W-1:0] drive_neg;

	assign sum_s3     = fwspd_pkg::SUM_W'(prop_s3) + fwspd_pkg::SUM_W'(integ_s3);
	assign quot_floor = sum_s3[fwspd_pkg::SUM_W-1:fwspd_pkg::GAIN_FRAC_BITS];
	assign round_up   = sum_s3[fwspd_pkg::SUM_W-1] &&
	                    (sum_s3[fwspd_pkg::GAIN_FRAC_BITS-1:0] != '0);
	assign quot       = quot_floor + QW'(round_up);

	always_comb begin
		if (quot > DRIVE_HI) begin
			drive_s3 = fwspd_pkg::DRIVE_W'(DRIVE_HI);
		end else if (quot < DRIVE_LO) begin
			drive_s3 = fwspd_pkg::DRIVE_W'(DRIVE_LO);
		end else begin
			drive_s3 = quot[fwspd_pkg::DRIVE_W-1:0];
		end
	end

	// H-bridge legs: magnitude goes to one leg, the other is zero
	assign rev_s3    = drive_s3[fwspd_pkg::DRIVE_W-1];
	assign drive_neg = -drive_s3;
	assign mag_s3    = rev_s3 ? drive_neg[fwspd_pkg::LEG_W-1:0]
	                          : drive_s3[fwspd_pkg::LEG_W-1:0];
	assign fwd_b     = (wheel_s3 == fwspd_pkg::WHEEL_FRONT_LEFT) ||
	                   (wheel_s3 == fwspd_pkg::WHEEL_REAR_RIGHT);

	always_comb begin
		if (fwd_b != rev_s3) begin
			leg_a_s3 = '0;
			leg_b_s3 = mag_s3;
		end else begin
			leg_a_s3 = mag_s3;
			leg_b_s3 = '0;
		end
	end

	// Output register
	logic [fwspd_pkg::WHEEL_W-1:0]        wheel_out_q;
	logic signed [fwspd_pkg::DRIVE_W-1:0] drive_q;
	logic                                 rev_q;
	logic [fwspd_pkg::LEG_W-1:0]          leg_a_q, leg_b_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			wheel_out_q <= wheel_s3;
			drive_q     <= drive_s3;
			rev_q       <= rev_s3;
			leg_a_q     <= leg_a_s3;
			leg_b_q     <= leg_b_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = wheel_out_q;
	assign m_tdata  = {leg_b_q, leg_a_q, rev_q, drive_q};

	// Checks
	`ASSERT_PROP(a_drive_range, clk, arst_n,
		out_valid_q |-> (drive_q <= 11'sd1000 && drive_q >= -11'sd1000),
		"drive outside clamp range")
	`ASSERT_NEVER(a_legs_exclusive, clk, arst_n,
		out_valid_q && leg_a_q != '0 && leg_b_q != '0,
		"both H-bridge legs driven")
	`ASSERT_PROP(a_leg_magnitude, clk, arst_n,
		out_valid_q |-> ((leg_a_q | leg_b_q) == (rev_q ? 10'(-drive_q) : 10'(drive_q))),
		"leg magnitude does not match drive")
	`ASSERT_PROP(a_integ_hold, clk, arst_n,
		!integ_upd |=> $stable(integ_q),
		"integral changed without an item leaving stage 1")

endmodule
`default_nettype wire
